### rtl/blk2s_pkg.sv
// ----------------------------------------------------------------------------
// BLAKE2s engine package
// Shared types, constants and helper functions for the BLAKE2s hash engine.
// ----------------------------------------------------------------------------
package blk2s_pkg;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned CHAIN_WORDS = 8;
    localparam logic [6:0]  BLOCK_BYTES = 7'd64;
    localparam logic [31:0] PARAM_BASE  = 32'h0101_0000;

    localparam logic [31:0] IV [CHAIN_WORDS] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    // Input and result items.
    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        last_of_run;
    } t_out_item;

    // Row rotation applied after each G evaluation.
    typedef enum logic [1:0] {
        ROT_COL    = 2'd0,
        ROT_DIAG   = 2'd1,
        ROT_UNDIAG = 2'd2
    } t_rot;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       hold;
        logic       wr_now;
        logic       wr_held;
        logic       load_v;
        logic       final_blk;
        logic       g_step;
        logic [1:0] phase;
        t_rot       rot_mode;
        logic [3:0] raddr;
        logic       fold;
        logic       out_load;
        logic [2:0] out_idx;
        logic       seed;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_has;
        logic in_last;
        logic fill_full;
        logic held_has;
        logic held_last;
        logic out_last;
    } t_dp_status;

    // Digest length as used: zero acts as one, anything above 32 as 32.
    function automatic logic [5:0] eff_len(input logic [5:0] len);
        logic [5:0] res;
        if (len == 6'd0) begin
            res = 6'd1;
        end else if (len > 6'd32) begin
            res = 6'd32;
        end else begin
            res = len;
        end
        return res;
    endfunction

    // Message word schedule; nibble k of a row holds entry k.
    function automatic logic [3:0] sigma(input logic [3:0] rnd, input logic [3:0] idx);
        logic [63:0] row;
        unique case (rnd)
            4'd0:    row = 64'hFEDCBA9876543210;
            4'd1:    row = 64'h357B20C16DF984AE;
            4'd2:    row = 64'h491763EADF250C8B;
            4'd3:    row = 64'h8F04A562EBCD1397;
            4'd4:    row = 64'hD386CB1EFA427509;
            4'd5:    row = 64'h91EF57D438B0A6C2;
            4'd6:    row = 64'hB8293670A4DEF15C;
            4'd7:    row = 64'hA2684F05931CE7BD;
            4'd8:    row = 64'h5A417D2C803B9EF6;
            4'd9:    row = 64'h0DC3E9BF5167482A;
            default: row = 64'hFEDCBA9876543210;
        endcase
        return row[{idx, 2'b00} +: 4];
    endfunction

endpackage

### rtl/blk2s_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module blk2s_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/blk2s_dp.sv
// ----------------------------------------------------------------------------
// BLAKE2s datapath
// Block buffer, chain value, byte counter, work vector with one G unit
// evaluated in four steps, and the digest output register.
// ----------------------------------------------------------------------------
module blk2s_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  blk2s_pkg::t_in_item   i_item,
    input  logic                  i_cfg_we,
    input  logic [5:0]            i_cfg_wdata,
    input  blk2s_pkg::t_ctl_cmd   i_cmd,
    output blk2s_pkg::t_dp_status o_status,
    output blk2s_pkg::t_out_item  o_item
);

    logic [5:0]           r_len;
    logic [31:0]          r_h [8];
    logic [63:0]          r_t;
    logic [6:0]           r_fill;
    logic [4:0]           r_limit;
    logic [3:0]           r_rd_idx;
    logic [31:0]          r_v [16];
    blk2s_pkg::t_in_item  r_hold;
    blk2s_pkg::t_out_item r_out;

    logic [31:0] n_v [16];
    logic [31:0] u [16];
    logic [31:0] ram_rdata;
    logic [31:0] msg;
    logic        wr_en;
    logic [31:0] wr_data;
    logic [2:0]  wr_cnt;
    logic [2:0]  now_cnt;
    logic [2:0]  held_cnt;
    logic [63:0] t_new;
    logic [6:0]  add_bytes;
    logic [5:0]  len_eff;
    logic [5:0]  cfg_eff;
    logic [5:0]  rem;
    logic [3:0]  nwords;
    logic [31:0] out_word;
    logic [31:0] ga, gb, gc, gd;
    logic [1:0]  shift;
    blk2s_pkg::t_in_item wr_item;

    // Effective byte count of an item.
    function automatic logic [2:0] item_cnt(input blk2s_pkg::t_in_item it);
        logic [2:0] c;
        if (!it.last_word || it.byte_count > 3'd4) begin
            c = 3'd4;
        end else begin
            c = it.byte_count;
        end
        return c;
    endfunction

    function automatic logic [31:0] mask_bytes(input logic [31:0] w, input logic [2:0] c);
        logic [31:0] res;
        unique case (c)
            3'd0:    res = 32'h0;
            3'd1:    res = {24'h0, w[7:0]};
            3'd2:    res = {16'h0, w[15:0]};
            3'd3:    res = {8'h0, w[23:0]};
            default: res = w;
        endcase
        return res;
    endfunction

    assign now_cnt  = item_cnt(i_item);
    assign held_cnt = item_cnt(r_hold);
    assign len_eff  = blk2s_pkg::eff_len(r_len);
    assign cfg_eff  = blk2s_pkg::eff_len(i_cfg_wdata);

    // Status toward the controller.
    always_comb begin
        o_status.in_has    = (now_cnt != 3'd0);
        o_status.in_last   = i_item.last_word;
        o_status.fill_full = (r_fill == blk2s_pkg::BLOCK_BYTES);
        o_status.held_has  = (held_cnt != 3'd0);
        o_status.held_last = r_hold.last_word;
        o_status.out_last  = r_out.last_of_run;
    end

    // Block buffer write: from the port directly or from the held item.
    always_comb begin
        wr_item = i_cmd.wr_held ? r_hold : i_item;
        wr_cnt  = i_cmd.wr_held ? held_cnt : now_cnt;
        wr_data = mask_bytes(wr_item.message_word, wr_cnt);
        wr_en   = (i_cmd.wr_now || i_cmd.wr_held) && (wr_cnt != 3'd0);
    end

    blk2s_ram #(
        .WIDTH(32),
        .DEPTH(blk2s_pkg::BLOCK_WORDS)
    ) u_block (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_fill[5:2]),
        .i_wdata(wr_data),
        .i_raddr(i_cmd.raddr),
        .o_rdata(ram_rdata)
    );

    // Words past the buffered data of the final block read as zero.
    assign msg = ({1'b0, r_rd_idx} < r_limit) ? ram_rdata : 32'h0;

    assign add_bytes = i_cmd.final_blk ? r_fill : blk2s_pkg::BLOCK_BYTES;
    assign t_new     = r_t + {57'h0, add_bytes};

    // One quarter of the G function on column zero, then the row rotation.
    always_comb begin
        ga = r_v[0];
        gb = r_v[4];
        gc = r_v[8];
        gd = r_v[12];
        for (int i = 0; i < 16; i++) begin
            u[i] = r_v[i];
        end
        unique case (i_cmd.phase)
            2'd0, 2'd2: begin
                u[0] = ga + gb + msg;
            end
            2'd1: begin
                u[12] = {gd[15:0] ^ ga[15:0], gd[31:16] ^ ga[31:16]};
                u[8]  = gc + u[12];
                u[4]  = {gb[11:0] ^ u[8][11:0], gb[31:12] ^ u[8][31:12]};
            end
            default: begin
                u[12] = {gd[7:0] ^ ga[7:0], gd[31:8] ^ ga[31:8]};
                u[8]  = gc + u[12];
                u[4]  = {gb[6:0] ^ u[8][6:0], gb[31:7] ^ u[8][31:7]};
            end
        endcase
        for (int i = 0; i < 16; i++) begin
            n_v[i] = u[i];
        end
        if (i_cmd.phase == 2'd3) begin
            for (int r = 0; r < 4; r++) begin
                unique case (i_cmd.rot_mode)
                    blk2s_pkg::ROT_DIAG:   shift = 2'(r + 1);
                    blk2s_pkg::ROT_UNDIAG: shift = 2'(1 - r);
                    default:               shift = 2'd1;
                endcase
                for (int j = 0; j < 4; j++) begin
                    n_v[4 * r + j] = u[4 * r + 32'(2'(j + 32'(shift)))];
                end
            end
        end
    end

    // Digest word selection and trimming.
    always_comb begin
        rem      = len_eff - {1'b0, i_cmd.out_idx, 2'b00};
        nwords   = 4'((7'(len_eff) + 7'd3) >> 2);
        out_word = r_h[i_cmd.out_idx];
        if (rem < 6'd4) begin
            out_word = mask_bytes(out_word, rem[2:0]);
        end
    end

    // Control state: length, chain value, counter and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= 6'd32;
            r_t    <= 64'h0;
            r_fill <= 7'd0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= blk2s_pkg::IV[i];
            end
            r_h[0] <= blk2s_pkg::IV[0] ^ blk2s_pkg::PARAM_BASE ^ 32'd32;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
                if (r_fill == 7'd0 && r_t == 64'h0) begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= blk2s_pkg::IV[i];
                    end
                    r_h[0] <= blk2s_pkg::IV[0] ^ (blk2s_pkg::PARAM_BASE | {26'h0, cfg_eff});
                end
            end
            if (wr_en) begin
                r_fill <= r_fill + {4'h0, wr_cnt};
            end
            if (i_cmd.load_v) begin
                r_t <= t_new;
                if (!i_cmd.final_blk) begin
                    r_fill <= 7'd0;
                end
            end
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] ^ r_v[i] ^ r_v[i + 8];
                end
            end
            if (i_cmd.seed) begin
                r_t    <= 64'h0;
                r_fill <= 7'd0;
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= blk2s_pkg::IV[i];
                end
                r_h[0] <= blk2s_pkg::IV[0] ^ (blk2s_pkg::PARAM_BASE | {26'h0, len_eff});
            end
        end
    end

    // Payload registers: held item, work vector and output word.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_cmd.raddr;
        if (i_cmd.hold) begin
            r_hold <= i_item;
        end
        if (i_cmd.load_v) begin
            r_limit <= i_cmd.final_blk ? 5'((r_fill + 7'd3) >> 2) : 5'd16;
            for (int i = 0; i < 8; i++) begin
                r_v[i]     <= r_h[i];
                r_v[i + 8] <= blk2s_pkg::IV[i];
            end
            r_v[12] <= blk2s_pkg::IV[4] ^ t_new[31:0];
            r_v[13] <= blk2s_pkg::IV[5] ^ t_new[63:32];
            if (i_cmd.final_blk) begin
                r_v[14] <= ~blk2s_pkg::IV[6];
            end
        end else if (i_cmd.g_step) begin
            for (int i = 0; i < 16; i++) begin
                r_v[i] <= n_v[i];
            end
        end
        if (i_cmd.out_load) begin
            r_out.digest_word <= out_word;
            r_out.last_of_run <= ({1'b0, i_cmd.out_idx} + 4'd1) == nwords;
        end
    end

    assign o_item = r_out;

endmodule

### rtl/blk2s_ctrl.sv
// ----------------------------------------------------------------------------
// BLAKE2s controller
// Sequences item intake, compressions (ten rounds of eight G evaluations in
// four steps each) and digest output.
// ----------------------------------------------------------------------------
module blk2s_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_stall,
    input  blk2s_pkg::t_dp_status i_status,
    output blk2s_pkg::t_ctl_cmd   o_cmd,
    output logic                  o_stall,
    output logic                  o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_INIT,
        S_ROUND,
        S_FOLD,
        S_PRESENT,
        S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_rnd, n_rnd;
    logic [2:0] r_g, n_g;
    logic [1:0] r_ph, n_ph;
    logic       r_final, n_final;
    logic [2:0] r_k, n_k;
    logic       r_valid, n_valid;

    logic [3:0] nx_rnd;
    logic [2:0] nx_g;

    // Position of the next G evaluation.
    always_comb begin
        if (r_g == 3'd7) begin
            nx_rnd = r_rnd + 4'd1;
            nx_g   = 3'd0;
        end else begin
            nx_rnd = r_rnd;
            nx_g   = r_g + 3'd1;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state  = r_state;
        n_rnd    = r_rnd;
        n_g      = r_g;
        n_ph     = r_ph;
        n_final  = r_final;
        n_k      = r_k;
        n_valid  = r_valid;
        o_cmd          = '0;
        o_cmd.final_blk = r_final;
        o_cmd.phase    = r_ph;
        o_cmd.rot_mode = blk2s_pkg::ROT_COL;
        o_cmd.out_idx  = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_status.in_has && i_status.fill_full) begin
                        o_cmd.hold = 1'b1;
                        n_final    = 1'b0;
                        n_state    = S_INIT;
                    end else begin
                        o_cmd.wr_now = 1'b1;
                        if (i_status.in_last) begin
                            n_final = 1'b1;
                            n_state = S_INIT;
                        end
                    end
                end
            end
            S_WRITE: begin
                o_cmd.wr_held = 1'b1;
                if (i_status.held_last) begin
                    n_final = 1'b1;
                    n_state = S_INIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_INIT: begin
                o_cmd.load_v = 1'b1;
                o_cmd.raddr  = blk2s_pkg::sigma(4'd0, 4'd0);
                n_rnd   = 4'd0;
                n_g     = 3'd0;
                n_ph    = 2'd0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.g_step = 1'b1;
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd1) begin
                    o_cmd.raddr = blk2s_pkg::sigma(r_rnd, {r_g, 1'b1});
                end else if (r_ph == 2'd3) begin
                    o_cmd.raddr = blk2s_pkg::sigma(nx_rnd, {nx_g, 1'b0});
                    if (r_g == 3'd3) begin
                        o_cmd.rot_mode = blk2s_pkg::ROT_DIAG;
                    end else if (r_g == 3'd7) begin
                        o_cmd.rot_mode = blk2s_pkg::ROT_UNDIAG;
                    end
                    n_rnd = nx_rnd;
                    n_g   = nx_g;
                    if (r_g == 3'd7 && r_rnd == 4'd9) begin
                        n_state = S_FOLD;
                    end
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state = r_final ? S_PRESENT : S_WRITE;
            end
            S_PRESENT: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_idx  = 3'd0;
                n_k     = 3'd0;
                n_valid = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stall) begin
                    if (i_status.out_last) begin
                        o_cmd.seed = 1'b1;
                        n_valid    = 1'b0;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_idx  = r_k + 3'd1;
                        n_k = r_k + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= 4'd0;
            r_g     <= 3'd0;
            r_ph    <= 2'd0;
            r_final <= 1'b0;
            r_k     <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            r_g     <= n_g;
            r_ph    <= n_ph;
            r_final <= n_final;
            r_k     <= n_k;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

### rtl/blake2s_hash_engine.sv
// ----------------------------------------------------------------------------
// BLAKE2s hash engine
// Unkeyed BLAKE2s with a configurable digest length of 1 to 32 bytes.
// ----------------------------------------------------------------------------
// Message words are taken one per cycle while no compression is pending. A
// compression runs the ten rounds on one shared G unit in four steps per G
// evaluation; a full block is only compressed once the next data item
// arrives, which is held and written after the compression. The last item
// of a message starts the final compression, after which ceil(digest_len/4)
// digest items are presented one per accepted handshake. The engine stalls
// its input until the last digest item is taken and then starts the next
// message. digest_len must be written only while the engine is idle, which
// it does not enforce; a write before any data of a message re-seeds it.
// ----------------------------------------------------------------------------
module blake2s_hash_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  blk2s_pkg::t_in_item  i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output blk2s_pkg::t_out_item o_item,
    input  logic                 i_cfg_we,
    input  logic [5:0]           i_cfg_wdata
);

    blk2s_pkg::t_ctl_cmd   cmd;
    blk2s_pkg::t_dp_status status;

    // Sequencing.
    blk2s_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_status(status),
        .o_cmd   (cmd),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    // Storage and arithmetic.
    blk2s_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_item     (o_item)
    );

endmodule

### tb/sv/blake2s_digest_checker.sv
// ----------------------------------------------------------------------------
// BLAKE2s digest checker
// Watches the message and digest channels of the hash engine, predicts each
// digest word with an independent BLAKE2s computation and compares it with
// the word that the engine delivers.
// ----------------------------------------------------------------------------
module blake2s_digest_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_stall,
    input  blk2s_pkg::t_in_item  i_item,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  blk2s_pkg::t_out_item i_res_item,
    input  logic                 i_cfg_we,
    input  logic [5:0]           i_cfg_wdata,
    output int                   o_errors,
    output int                   o_pending
);

    // Message schedule, one row per round.
    localparam logic [3:0] SCHED [10][16] = '{
        '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15 },
        '{ 14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3 },
        '{ 11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4 },
        '{ 7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8 },
        '{ 9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13 },
        '{ 2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9 },
        '{ 12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11 },
        '{ 13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10 },
        '{ 6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5 },
        '{ 10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0 }
    };
    localparam logic [3:0] LANES [8][4] = '{
        '{ 0, 4, 8, 12 }, '{ 1, 5, 9, 13 }, '{ 2, 6, 10, 14 }, '{ 3, 7, 11, 15 },
        '{ 0, 5, 10, 15 }, '{ 1, 6, 11, 12 }, '{ 2, 7, 8, 13 }, '{ 3, 4, 9, 14 }
    };

    logic [5:0]           len_reg;
    logic [31:0]          chain [8];
    logic [63:0]          byte_total;
    logic [31:0]          blk [16];
    int unsigned          fill;
    blk2s_pkg::t_out_item digest_fifo [$];

    assign o_pending = digest_fifo.size();

    function automatic logic [5:0] used_len(input logic [5:0] len);
        if (len == 6'd0) return 6'd1;
        if (len > 6'd32) return 6'd32;
        return len;
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic reseed();
        for (int i = 0; i < 8; i++) chain[i] = blk2s_pkg::IV[i];
        chain[0] ^= blk2s_pkg::PARAM_BASE | 32'(used_len(len_reg));
    endtask

    // One compression of the buffered block into the chain value.
    task automatic compress(input int unsigned add, input logic fin);
        logic [31:0] v [16];
        logic [3:0] a, b, c, d;
        byte_total += 64'(add);
        for (int i = 0; i < 8; i++) begin
            v[i] = chain[i];
            v[i + 8] = blk2s_pkg::IV[i];
        end
        v[12] ^= byte_total[31:0];
        v[13] ^= byte_total[63:32];
        if (fin) v[14] = ~v[14];
        for (int r = 0; r < 10; r++) begin
            for (int g = 0; g < 8; g++) begin
                a = LANES[g][0]; b = LANES[g][1]; c = LANES[g][2]; d = LANES[g][3];
                v[a] = v[a] + v[b] + blk[SCHED[r][2*g]];
                v[d] = ror(v[d] ^ v[a], 16);
                v[c] = v[c] + v[d];
                v[b] = ror(v[b] ^ v[c], 12);
                v[a] = v[a] + v[b] + blk[SCHED[r][2*g+1]];
                v[d] = ror(v[d] ^ v[a], 8);
                v[c] = v[c] + v[d];
                v[b] = ror(v[b] ^ v[c], 7);
            end
        end
        for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i + 8];
    endtask

    // Absorb one accepted message item and queue any digest words.
    task automatic absorb(input blk2s_pkg::t_in_item it);
        int unsigned cnt, len, nw, rem;
        logic [31:0] w;
        blk2s_pkg::t_out_item o;
        w = it.message_word;
        cnt = it.byte_count;
        if (!it.last_word || cnt > 4) cnt = 4;
        if (cnt > 0) begin
            if (fill >= 64) begin
                compress(64, 1'b0);
                fill = 0;
            end
            if (cnt < 4) w &= (32'd1 << (8 * cnt)) - 1;
            blk[fill >> 2] = w;
            fill += cnt;
        end
        if (it.last_word) begin
            for (int i = (fill + 3) >> 2; i < 16; i++) blk[i] = '0;
            compress(fill, 1'b1);
            len = used_len(len_reg);
            nw = (len + 3) / 4;
            for (int k = 0; k < nw; k++) begin
                w = chain[k];
                rem = len - 4 * k;
                if (rem < 4) w &= (32'd1 << (8 * rem)) - 1;
                o.digest_word = w;
                o.last_of_run = (k + 1 == nw);
                digest_fifo.push_back(o);
            end
            byte_total = '0;
            fill = 0;
            reseed();
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("ERROR %0t: %s got %08h expected %08h", $time, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    // Track configuration, inputs and results at every rising edge.
    always @(posedge i_clk) begin
        blk2s_pkg::t_out_item want;
        if (!i_rst_n) begin
            len_reg = 6'd32;
            byte_total = '0;
            fill = 0;
            reseed();
            digest_fifo.delete();
        end else begin
            if (i_cfg_we) begin
                len_reg = i_cfg_wdata;
                if (fill == 0 && byte_total == 0) reseed();
            end
            if (i_valid && !i_stall) absorb(i_item);
            if (i_res_valid && !i_res_stall) begin
                if (digest_fifo.size() == 0) begin
                    report("unexpected digest word", i_res_item.digest_word, '0);
                end else begin
                    want = digest_fifo.pop_front();
                    if (i_res_item.digest_word !== want.digest_word)
                        report("digest_word", i_res_item.digest_word, want.digest_word);
                    if (i_res_item.last_of_run !== want.last_of_run)
                        report("last_of_run", 32'(i_res_item.last_of_run),
                               32'(want.last_of_run));
                end
            end
        end
    end

endmodule

### tb/sv/tb_blake2s_hash_engine.sv
// ----------------------------------------------------------------------------
// BLAKE2s hash engine testbench
// Drives directed and random messages under several digest lengths with
// random idling on both channels; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_blake2s_hash_engine;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 in_stall;
    blk2s_pkg::t_in_item  in_item;
    logic                 out_valid;
    logic                 out_stall;
    blk2s_pkg::t_out_item out_item;
    logic                 cfg_we;
    logic [5:0]           cfg_wdata;
    int                   errors;
    int                   pending;
    logic                 hold_off;

    blake2s_hash_engine uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_item     (in_item),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_item     (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    blake2s_digest_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_stall    (in_stall),
        .i_item     (in_item),
        .i_res_valid(out_valid),
        .i_res_stall(out_stall),
        .i_res_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on run time.
    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

    // Send one item, waiting a random number of idle cycles first.
    task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        in_item.message_word = w;
        in_item.byte_count = cnt;
        in_item.last_word = lst;
        in_valid = 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    // Send a whole message of the given byte length with random content.
    task automatic send_message(input int nbytes);
        int left;
        left = nbytes;
        if (nbytes == 0) begin
            send_word($urandom, 3'd0, 1'b1);
        end else begin
            while (left > 4) begin
                send_word($urandom, ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'd4, 1'b0);
                left -= 4;
            end
            send_word($urandom, 3'(left), 1'b1);
        end
    endtask

    // Write the digest length once the engine has drained.
    task automatic set_len(input logic [5:0] len);
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_wdata = len;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Receiver: random stall per item, with one long hold-off.
    initial begin
        int gap;
        out_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_stall = 1'b1;
                repeat (2000) @(negedge i_clk);
                hold_off = 1'b0;
            end
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) gap = 0;
            out_stall = 1'b1;
            repeat (gap) @(negedge i_clk);
            out_stall = 1'b0;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
        end
    end

    initial begin
        logic [5:0] lens [6];
        int wait_cycles;
        lens = '{6'd1, 6'd0, 6'd63, 6'd17, 6'd32, 6'd6};
        hold_off = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty message, field extremes, block boundaries.
        send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hA5A5_5A5A, 3'd1, 1'b1);
        send_word(32'h1234_5678, 3'd3, 1'b0);
        send_word(32'h8765_4321, 3'd2, 1'b1);
        send_message(64);
        send_message(65);
        for (int i = 0; i < 16; i++) send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
        send_word(32'h0, 3'd0, 1'b1);

        // Length change in mid message, then one before any data.
        send_word($urandom, 3'd4, 1'b0);
        set_len(6'd5);
        send_word($urandom, 3'd2, 1'b1);

        // Random phases at several digest lengths.
        for (int p = 0; p < 6; p++) begin
            set_len(lens[p]);
            if (p == 3) hold_off = 1'b1;
            for (int m = 0; m < 6; m++)
                send_message(($urandom_range(0, 5) == 0) ? $urandom_range(60, 140)
                                                         : $urandom_range(0, 24));
        end

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        if (pending != 0) begin
            $display("simulation failed");
            $finish;
        end
        repeat (400) @(negedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
